[hdl/salcd_pkg.sv]
package salcd_pkg;

	// default sizes of the directory storage
	localparam int MAX_SETS_DEF = 1024;
	localparam int MAX_WAYS_DEF = 16;

	// address bits kept from the byte address and the victim address
	localparam int ADDR_BITS = 32;
	localparam logic [31:0] ADDR_MASK = (ADDR_BITS >= 32) ? 32'hFFFF_FFFF :
		32'((64'd1 << ADDR_BITS) - 64'd1);

	// field widths
	localparam int CMD_W  = 3;
	localparam int WORD_W = 32;
	localparam int LBB_W  = 4;
	localparam int LS_W   = 4;
	localparam int WIU_W  = 5;
	localparam int PADDR_W = 4;
	localparam int REG_IDX_W = 2;

	// commands
	localparam logic [CMD_W-1:0] CMD_PROBE      = 3'd0;
	localparam logic [CMD_W-1:0] CMD_READ_TOUCH = 3'd1;
	localparam logic [CMD_W-1:0] CMD_UPDATE     = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ALLOCATE   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_INVALIDATE = 3'd4;

	// configuration register indexes (byte address 4*index)
	localparam logic [REG_IDX_W-1:0] REG_LOG2_BLOCK_BYTES = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_LOG2_SETS        = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_WAYS_IN_USE      = 2'd2;

	// register reset values
	localparam logic [LBB_W-1:0] LBB_RESET = 4'd6;
	localparam logic [LS_W-1:0]  LS_RESET  = 4'd0;
	localparam logic [WIU_W-1:0] WIU_RESET = 5'd1;

	// one directory entry
	typedef struct packed {
		logic              valid;
		logic              dirty;
		logic [WORD_W-1:0] blk;
		logic [WORD_W-1:0] rec;
	} entry_t;

endpackage

[hdl/set_assoc_lru_cache_directory.sv]
// set-associative write-back cache tag directory with timestamp lru
//
// command channel: a word (cmd, byte_address, timestamp, dirty_in) is taken at a
// rising edge with start high and busy low; cmd selects probe, read touch,
// update, allocate or invalidate; codes 5 to 7 change nothing and answer zero
// result channel: done is high for exactly one cycle with hit, dirty_out,
// filled_empty, victim_valid, victim_address, victim_timestamp and victim_dirty
// the receiver cannot stall, so the result is simply presented for that cycle
// config: apb-style port, log2_block_bytes at 0x0, log2_sets at 0x4,
// ways_in_use at 0x8; pready is always high, write only while idle
//
// scan: the ways of the selected set are read from the
// entry memory one per cycle through its single read port and checked by one
// tag compare and one timestamp compare; the done strobe follows the scan, a
// drain state and a finish state; busy drops in the cycle done is shown,
// so the next word can be taken at the edge that ends it
//
// reset: the registers go to 6 / 0 / 1 and a clearing pass writes every entry
// of the memory empty, one entry a cycle, 2**(set bits + way bits) entries
// (16384 at the default size); busy stays high during the pass
module set_assoc_lru_cache_directory #(
	parameter int MAX_SETS = salcd_pkg::MAX_SETS_DEF,
	parameter int MAX_WAYS = salcd_pkg::MAX_WAYS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// command channel
	input  logic                                  start,
	output logic                                  busy,
	input  logic [salcd_pkg::CMD_W-1:0]           cmd,
	input  logic [salcd_pkg::WORD_W-1:0]          byte_address,
	input  logic [salcd_pkg::WORD_W-1:0]          timestamp,
	input  logic                                  dirty_in,
	// result channel
	output logic                                  done,
	output logic                                  hit,
	output logic                                  dirty_out,
	output logic                                  filled_empty,
	output logic                                  victim_valid,
	output logic [salcd_pkg::WORD_W-1:0]          victim_address,
	output logic [salcd_pkg::WORD_W-1:0]          victim_timestamp,
	output logic                                  victim_dirty,
	// configuration port
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [salcd_pkg::PADDR_W-1:0]         paddr,
	input  logic [salcd_pkg::WORD_W-1:0]          pwdata,
	output logic [salcd_pkg::WORD_W-1:0]          prdata,
	output logic                                  pready
);

	localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WCNT_W    = $clog2(MAX_WAYS + 1);
	localparam int IDX_W     = SET_W + WAY_W;
	localparam int DEPTH     = 2 ** IDX_W;
	localparam int SETLG_MAX = $clog2(MAX_SETS + 1) - 1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t state_q;

	// configuration registers
	logic [salcd_pkg::LBB_W-1:0] log2_block_bytes_q;
	logic [salcd_pkg::LS_W-1:0]  log2_sets_q;
	logic [salcd_pkg::WIU_W-1:0] ways_in_use_q;

	// entry memory, one entry per {set, way}
	salcd_pkg::entry_t mem_q [DEPTH];
	salcd_pkg::entry_t rdata_s1;
	logic [WAY_W-1:0]  way_s1;
	logic              proc_vld_s1;

	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	salcd_pkg::entry_t mem_wdata;
	logic [IDX_W-1:0]  mem_raddr;

	logic [IDX_W-1:0]  clr_idx_q;

	// item held during the scan
	logic [salcd_pkg::CMD_W-1:0]  cmd_q;
	logic [salcd_pkg::WORD_W-1:0] blk_q;
	logic [salcd_pkg::WORD_W-1:0] ts_q;
	logic                         din_q;
	logic [SET_W-1:0]             set_q;
	logic [salcd_pkg::LBB_W-1:0]  shift_q;
	logic [WAY_W-1:0]             last_way_q;
	logic [WAY_W-1:0]             rd_way_q;

	// scan results
	logic                         found_q;
	logic [WAY_W-1:0]             found_way_q;
	logic                         found_dirty_q;
	logic                         empty_q;
	logic [WAY_W-1:0]             empty_way_q;
	logic [WAY_W-1:0]             best_way_q;
	logic [salcd_pkg::WORD_W-1:0] best_ts_q;
	logic [salcd_pkg::WORD_W-1:0] best_blk_q;
	logic                         best_dirty_q;

	// result registers
	logic                         done_q;
	logic                         hit_q;
	logic                         dirty_out_q;
	logic                         filled_empty_q;
	logic                         victim_valid_q;
	logic [salcd_pkg::WORD_W-1:0] victim_address_q;
	logic [salcd_pkg::WORD_W-1:0] victim_timestamp_q;
	logic                         victim_dirty_q;

	// accept side decode
	logic                         accept;
	logic                         cfg_wr;
	logic [salcd_pkg::REG_IDX_W-1:0] reg_idx;
	logic [salcd_pkg::WORD_W-1:0] addr_m;
	logic [salcd_pkg::WORD_W-1:0] blk_in;
	logic [salcd_pkg::LS_W-1:0]   eff_ls;
	logic [SET_W:0]               set_mask_w;
	logic [WCNT_W-1:0]            eff_ways;

	// per-way check and finish decode
	logic                         way_match;
	logic                         way_older;
	logic [WAY_W-1:0]             wr_way;
	logic                         fin_we;
	salcd_pkg::entry_t            fin_entry;
	logic [salcd_pkg::WORD_W-1:0] victim_addr_w;
	logic                         is_lookup;
	logic                         is_alloc;
	logic                         evict;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign reg_idx = paddr[salcd_pkg::PADDR_W-1:2];

	assign done             = done_q;
	assign hit              = hit_q;
	assign dirty_out        = dirty_out_q;
	assign filled_empty     = filled_empty_q;
	assign victim_valid     = victim_valid_q;
	assign victim_address   = victim_address_q;
	assign victim_timestamp = victim_timestamp_q;
	assign victim_dirty     = victim_dirty_q;

	// register read back
	always_comb begin
		unique case (reg_idx)
			salcd_pkg::REG_LOG2_BLOCK_BYTES: prdata = 32'(log2_block_bytes_q);
			salcd_pkg::REG_LOG2_SETS:        prdata = 32'(log2_sets_q);
			salcd_pkg::REG_WAYS_IN_USE:      prdata = 32'(ways_in_use_q);
			default:                         prdata = '0;
		endcase
	end

	// block number and set of the incoming word
	assign addr_m = byte_address & salcd_pkg::ADDR_MASK;
	assign blk_in = addr_m >> log2_block_bytes_q;

	always_comb begin
		// set bits saturate at the largest power of two within the set count
		if (32'(log2_sets_q) > SETLG_MAX) begin
			eff_ls = salcd_pkg::LS_W'(SETLG_MAX);
		end else begin
			eff_ls = log2_sets_q;
		end
		set_mask_w = ((SET_W + 1)'(1) << eff_ls) - (SET_W + 1)'(1);
	end

	always_comb begin
		// zero ways acts as one, too many saturates
		if (ways_in_use_q == '0) begin
			eff_ways = WCNT_W'(1);
		end else if (32'(ways_in_use_q) > MAX_WAYS) begin
			eff_ways = WCNT_W'(MAX_WAYS);
		end else begin
			eff_ways = WCNT_W'(ways_in_use_q);
		end
	end

	// shared compare unit, one way per cycle
	assign way_match = rdata_s1.valid && (rdata_s1.blk == blk_q);
	assign way_older = rdata_s1.rec < best_ts_q;

	// commands that answer with hit, and allocate with or without a victim
	assign is_lookup = (cmd_q == salcd_pkg::CMD_PROBE) || (cmd_q == salcd_pkg::CMD_READ_TOUCH)
		|| (cmd_q == salcd_pkg::CMD_UPDATE) || (cmd_q == salcd_pkg::CMD_INVALIDATE);
	assign is_alloc  = (cmd_q == salcd_pkg::CMD_ALLOCATE);
	assign evict     = is_alloc && !empty_q;

	// final write and victim address
	always_comb begin
		if (cmd_q == salcd_pkg::CMD_ALLOCATE) begin
			wr_way = empty_q ? empty_way_q : best_way_q;
		end else begin
			wr_way = found_way_q;
		end
		fin_entry.valid = 1'b1;
		fin_entry.dirty = din_q;
		fin_entry.blk   = blk_q;
		fin_entry.rec   = ts_q;
		fin_we          = 1'b0;
		case (cmd_q)
			salcd_pkg::CMD_READ_TOUCH: begin
				fin_we          = found_q;
				fin_entry.dirty = found_dirty_q;
			end
			salcd_pkg::CMD_UPDATE: begin
				fin_we = found_q;
			end
			salcd_pkg::CMD_ALLOCATE: begin
				fin_we = 1'b1;
			end
			salcd_pkg::CMD_INVALIDATE: begin
				fin_we          = found_q;
				fin_entry.valid = 1'b0;
				fin_entry.dirty = 1'b0;
			end
			default: begin
				fin_we = 1'b0;
			end
		endcase
		victim_addr_w = (best_blk_q << shift_q) & salcd_pkg::ADDR_MASK;
	end

	// memory port control
	always_comb begin
		mem_raddr = {set_q, rd_way_q};
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_idx_q;
			mem_wdata = '0;
		end else begin
			mem_we    = (state_q == ST_FINISH) && fin_we;
			mem_waddr = {set_q, wr_way};
			mem_wdata = fin_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rdata_s1 <= mem_q[mem_raddr];
		way_s1   <= rd_way_q;
	end

	// item capture and lru tracking
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q      <= cmd;
			blk_q      <= blk_in;
			ts_q       <= timestamp;
			din_q      <= dirty_in;
			set_q      <= blk_in[SET_W-1:0] & set_mask_w[SET_W-1:0];
			shift_q    <= log2_block_bytes_q;
			last_way_q <= WAY_W'(eff_ways - WCNT_W'(1));
		end
		if (proc_vld_s1) begin
			if (way_match && !found_q) begin
				found_way_q   <= way_s1;
				found_dirty_q <= rdata_s1.dirty;
			end
			if (!rdata_s1.valid && !empty_q) begin
				empty_way_q <= way_s1;
			end
			// way 0 seeds the search, later ways win only when strictly older
			if (way_s1 == '0 || way_older) begin
				best_way_q   <= way_s1;
				best_ts_q    <= rdata_s1.rec;
				best_blk_q   <= rdata_s1.blk;
				best_dirty_q <= rdata_s1.dirty;
			end
		end
	end

	// sequencer, config registers and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= ST_CLEAR;
			clr_idx_q          <= '0;
			rd_way_q           <= '0;
			proc_vld_s1        <= 1'b0;
			found_q            <= 1'b0;
			empty_q            <= 1'b0;
			log2_block_bytes_q <= salcd_pkg::LBB_RESET;
			log2_sets_q        <= salcd_pkg::LS_RESET;
			ways_in_use_q      <= salcd_pkg::WIU_RESET;
			done_q             <= 1'b0;
			hit_q              <= 1'b0;
			dirty_out_q        <= 1'b0;
			filled_empty_q     <= 1'b0;
			victim_valid_q     <= 1'b0;
			victim_address_q   <= '0;
			victim_timestamp_q <= '0;
			victim_dirty_q     <= 1'b0;
		end else begin
			done_q      <= (state_q == ST_FINISH);
			proc_vld_s1 <= (state_q == ST_SCAN);

			if (cfg_wr) begin
				unique case (reg_idx)
					salcd_pkg::REG_LOG2_BLOCK_BYTES: begin
						log2_block_bytes_q <= pwdata[salcd_pkg::LBB_W-1:0];
					end
					salcd_pkg::REG_LOG2_SETS: begin
						log2_sets_q <= pwdata[salcd_pkg::LS_W-1:0];
					end
					salcd_pkg::REG_WAYS_IN_USE: begin
						ways_in_use_q <= pwdata[salcd_pkg::WIU_W-1:0];
					end
					default: begin
					end
				endcase
			end

			if (proc_vld_s1) begin
				if (way_match) begin
					found_q <= 1'b1;
				end
				if (!rdata_s1.valid) begin
					empty_q <= 1'b1;
				end
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + IDX_W'(1);
					if (clr_idx_q == IDX_W'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						rd_way_q <= '0;
						found_q  <= 1'b0;
						empty_q  <= 1'b0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// one read per way, the read data lands in the next cycle
					rd_way_q <= rd_way_q + WAY_W'(1);
					if (rd_way_q == last_way_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					hit_q              <= is_lookup && found_q;
					dirty_out_q        <= (cmd_q == salcd_pkg::CMD_READ_TOUCH)
						&& found_q && found_dirty_q;
					filled_empty_q     <= is_alloc && empty_q;
					victim_valid_q     <= evict;
					victim_address_q   <= evict ? victim_addr_w : '0;
					victim_timestamp_q <= evict ? best_ts_q : '0;
					victim_dirty_q     <= evict && best_dirty_q;
					state_q            <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
